/* src/lspd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspd_pkg
// Types and constants shared by the lidar scan packet decoder modules.
// ----------------------------------------------------------------------------
package lspd_pkg;

    localparam logic [7:0]  SYNC1      = 8'hAA;
    localparam logic [7:0]  SYNC2      = 8'h55;
    localparam logic [7:0]  TYPE_FRAME = 8'd1;
    localparam logic [13:0] LIMIT_MAX  = 14'd10000;
    localparam logic [13:0] LIMIT_DEF  = 14'd1000;
    localparam logic [16:0] SPAN_WRAP  = 17'd23040;
    localparam logic [4:0]  DIV_STEPS  = 5'd23;
    localparam logic [4:0]  COR_LAST   = 5'd15;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_SYNC2  = 4'd1,
        PH_TYPE   = 4'd2,
        PH_COUNT  = 4'd3,
        PH_FSA_LO = 4'd4,
        PH_FSA_HI = 4'd5,
        PH_LSA_LO = 4'd6,
        PH_LSA_HI = 4'd7,
        PH_CS_LO  = 4'd8,
        PH_CS_HI  = 4'd9,
        PH_S_LO   = 4'd10,
        PH_S_HI   = 4'd11
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_MARK
    } t_state;

    typedef enum logic [2:0] {
        AU_IDLE,
        AU_MUL,
        AU_DIV,
        AU_COR,
        AU_FIN
    } t_au_state;

    typedef struct packed {
        logic [14:0] fa;
        logic [14:0] la;
        logic [7:0]  idx;
        logic [7:0]  tot;
        logic [13:0] distance;
    } t_au_req;

    // arctangent of 2^-k in degrees * 65536
    function automatic logic signed [23:0] atan_step(input logic [3:0] k);
        logic signed [23:0] v;
        case (k)
            4'd0:    v = 24'sd2949120;
            4'd1:    v = 24'sd1740967;
            4'd2:    v = 24'sd919879;
            4'd3:    v = 24'sd466945;
            4'd4:    v = 24'sd234379;
            4'd5:    v = 24'sd117304;
            4'd6:    v = 24'sd58666;
            4'd7:    v = 24'sd29335;
            4'd8:    v = 24'sd14668;
            4'd9:    v = 24'sd7334;
            4'd10:   v = 24'sd3667;
            4'd11:   v = 24'sd1833;
            4'd12:   v = 24'sd917;
            4'd13:   v = 24'sd458;
            4'd14:   v = 24'sd229;
            default: v = 24'sd115;
        endcase
        return v;
    endfunction

endpackage

/* src/lspd_angle.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspd_angle
// Sequenced angle unit: interpolation by restoring division, then a
// 16-step CORDIC arctangent correction, then sum and saturation.
// ----------------------------------------------------------------------------
module lspd_angle (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  lspd_pkg::t_au_req    i_req,
    output logic                 o_done,
    output logic signed [16:0]   o_angle
);

    lspd_pkg::t_au_state r_state, n_state;

    logic [14:0]        r_f;
    logic signed [16:0] r_span;
    logic [7:0]         r_idx;
    logic [7:0]         r_tot;
    logic [13:0]        r_d;
    logic signed [21:0] r_t;
    logic               r_neg;
    logic [23:0]        r_quo;
    logic [7:0]         r_rem;
    logic signed [37:0] r_x;
    logic signed [37:0] r_y;
    logic signed [23:0] r_acc;
    logic [4:0]         r_cnt;

    logic signed [16:0] w_diff;
    logic signed [16:0] w_span;
    logic [21:0]        w_d100;
    logic [16:0]        w_mag;
    logic [23:0]        w_prod;
    logic [8:0]         w_trial;
    logic               w_bit;
    logic signed [37:0] w_dx;
    logic signed [37:0] w_dy;
    logic signed [18:0] w_interp;
    logic signed [23:0] w_accr;
    logic signed [23:0] w_corr;
    logic signed [18:0] w_ang;

    always_comb begin
        w_diff = $signed({2'b00, i_req.la}) - $signed({2'b00, i_req.fa});
        w_span = (i_req.la < i_req.fa) ? (w_diff + $signed(lspd_pkg::SPAN_WRAP)) : w_diff;
        w_d100 = {8'b0, i_req.distance} * 22'd100;
        w_mag  = r_span[16] ? 17'(-r_span) : 17'(r_span);
        w_prod = w_mag[15:0] * r_idx;
        w_trial = {r_rem, r_quo[23]};
        w_bit   = (w_trial >= {1'b0, r_tot});
        w_dx = r_y >>> r_cnt[3:0];
        w_dy = r_x >>> r_cnt[3:0];
        w_interp = r_neg ? -$signed({3'b000, r_quo[15:0]}) : $signed({3'b000, r_quo[15:0]});
        w_accr = r_acc + 24'sd512;
        w_corr = w_accr >>> 10;
        w_ang  = $signed({4'b0000, r_f}) + w_interp - w_corr[18:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lspd_pkg::AU_IDLE: if (i_start) n_state = lspd_pkg::AU_MUL;
            lspd_pkg::AU_MUL:  n_state = lspd_pkg::AU_DIV;
            lspd_pkg::AU_DIV:  if (r_cnt == 5'd0) n_state = lspd_pkg::AU_COR;
            lspd_pkg::AU_COR:  if (r_cnt == lspd_pkg::COR_LAST) n_state = lspd_pkg::AU_FIN;
            lspd_pkg::AU_FIN:  n_state = lspd_pkg::AU_IDLE;
            default:           n_state = lspd_pkg::AU_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == lspd_pkg::AU_FIN);
        if (w_ang > 19'sd65535) begin
            o_angle = 17'h0FFFF;
        end else if (w_ang < -19'sd8192) begin
            o_angle = -17'sd8192;
        end else begin
            o_angle = w_ang[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lspd_pkg::AU_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lspd_pkg::AU_IDLE: begin
                r_f    <= i_req.fa;
                r_span <= w_span;
                r_idx  <= i_req.idx;
                r_tot  <= i_req.tot;
                r_d    <= i_req.distance;
                r_t    <= $signed(w_d100) - 22'sd9015;
            end
            lspd_pkg::AU_MUL: begin
                r_neg <= r_span[16];
                r_quo <= w_prod;
                r_rem <= 8'd0;
                r_x   <= $signed({24'b0, r_d}) * 38'sd901500;
                r_y   <= r_t * 38'sd1916;
                r_acc <= 24'sd0;
                r_cnt <= lspd_pkg::DIV_STEPS;
            end
            lspd_pkg::AU_DIV: begin
                r_rem <= w_bit ? 8'(w_trial - {1'b0, r_tot}) : w_trial[7:0];
                r_quo <= {r_quo[22:0], w_bit};
                r_cnt <= (r_cnt == 5'd0) ? 5'd0 : r_cnt - 5'd1;
            end
            lspd_pkg::AU_COR: begin
                if (r_d != 14'd0 && r_y > 38'sd0) begin
                    r_x   <= r_x + w_dx;
                    r_y   <= r_y - w_dy;
                    r_acc <= r_acc + lspd_pkg::atan_step(r_cnt[3:0]);
                end else if (r_d != 14'd0 && r_y < 38'sd0) begin
                    r_x   <= r_x - w_dx;
                    r_y   <= r_y + w_dy;
                    r_acc <= r_acc - lspd_pkg::atan_step(r_cnt[3:0]);
                end
                r_cnt <= r_cnt + 5'd1;
            end
            default: begin
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lspd_pkg::AU_COR) |-> (r_cnt <= lspd_pkg::COR_LAST))
        else $error("cordic step count out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lspd_pkg::AU_DIV) |-> (r_rem < r_tot))
        else $error("division remainder not below divisor");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == lspd_pkg::AU_IDLE))
        else $error("angle unit did not return to idle");

endmodule

/* src/lidar_scan_packet_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_packet_decoder
// Parses the lidar byte stream into measured points and end-of-frame markers.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  input    | i_in_valid / o_in_stall    | i_rx_byte
//  output   | o_out_valid / i_out_stall  | o_kind o_angle_q6 o_distance
//           |                            | o_frame_number o_last
//  config   | i_cfg_we                   | i_cfg_wdata
//
//  A sample high byte that yields a point runs through the angle unit: a
//  setup step, 24 divide steps, 16 CORDIC steps and a sum. The input
//  stalls while a result waits in the output register, the angle unit is
//  busy or an end-of-frame marker waits to be issued. Reset is synchronous.
// ----------------------------------------------------------------------------
module lidar_scan_packet_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_kind,
    output logic signed [16:0]   o_angle_q6,
    output logic [13:0]          o_distance,
    output logic [15:0]          o_frame_number,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [13:0]          i_cfg_wdata
);

    lspd_pkg::t_phase r_phase, n_phase;
    lspd_pkg::t_state r_state, n_state;

    logic [7:0]  r_ptype, n_ptype;
    logic [7:0]  r_total, n_total;
    logic [14:0] r_fa, n_fa;
    logic [14:0] r_la, n_la;
    logic [7:0]  r_lo, n_lo;
    logic [7:0]  r_sidx, n_sidx;
    logic [13:0] r_pts, n_pts;
    logic [15:0] r_fc, n_fc;
    logic [13:0] r_max;
    logic        r_mk;
    logic [13:0] r_dist;
    logic [15:0] r_fn;

    logic               r_ov;
    logic               r_kind;
    logic signed [16:0] r_ang;
    logic [13:0]        r_odist;
    logic [15:0]        r_ofn;
    logic               r_last;

    logic        w_acc;
    logic        w_pt;
    logic        w_mk;
    logic [15:0] w_word;
    logic [13:0] w_lim;
    logic [7:0]  w_sinc;
    logic        w_start;
    logic        w_xfer;
    logic        w_done;
    logic signed [16:0] w_angle;
    lspd_pkg::t_au_req w_req;

    assign w_acc  = i_in_valid && !o_in_stall;
    assign w_xfer = r_ov && !i_out_stall;
    assign w_word = {i_rx_byte, r_lo};
    assign w_lim  = (r_max == 14'd0 || r_max > lspd_pkg::LIMIT_MAX) ? lspd_pkg::LIMIT_DEF : r_max;
    assign w_sinc = r_sidx + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_ptype = r_ptype;
        n_total = r_total;
        n_fa    = r_fa;
        n_la    = r_la;
        n_lo    = r_lo;
        n_sidx  = r_sidx;
        n_pts   = r_pts;
        n_fc    = r_fc;
        w_pt    = 1'b0;
        w_mk    = 1'b0;
        case (r_phase)
            lspd_pkg::PH_HUNT: if (i_rx_byte == lspd_pkg::SYNC1) n_phase = lspd_pkg::PH_SYNC2;
            lspd_pkg::PH_SYNC2: begin
                n_phase = (i_rx_byte == lspd_pkg::SYNC2) ? lspd_pkg::PH_TYPE : lspd_pkg::PH_HUNT;
            end
            lspd_pkg::PH_TYPE: begin
                n_ptype = i_rx_byte;
                n_phase = lspd_pkg::PH_COUNT;
            end
            lspd_pkg::PH_COUNT: begin
                n_total = i_rx_byte;
                n_phase = lspd_pkg::PH_FSA_LO;
            end
            lspd_pkg::PH_FSA_LO: begin
                n_lo    = i_rx_byte;
                n_phase = lspd_pkg::PH_FSA_HI;
            end
            lspd_pkg::PH_FSA_HI: begin
                n_fa    = w_word[15:1];
                n_phase = lspd_pkg::PH_LSA_LO;
            end
            lspd_pkg::PH_LSA_LO: begin
                n_lo    = i_rx_byte;
                n_phase = lspd_pkg::PH_LSA_HI;
            end
            lspd_pkg::PH_LSA_HI: begin
                n_la    = w_word[15:1];
                n_phase = lspd_pkg::PH_CS_LO;
            end
            lspd_pkg::PH_CS_LO: n_phase = lspd_pkg::PH_CS_HI;
            lspd_pkg::PH_CS_HI: begin
                n_sidx = 8'd0;
                if (r_total == 8'd0) begin
                    n_phase = lspd_pkg::PH_HUNT;
                    w_mk    = (r_ptype == lspd_pkg::TYPE_FRAME);
                end else begin
                    n_phase = lspd_pkg::PH_S_LO;
                end
            end
            lspd_pkg::PH_S_LO: begin
                n_lo    = i_rx_byte;
                n_phase = lspd_pkg::PH_S_HI;
            end
            lspd_pkg::PH_S_HI: begin
                if (r_pts < w_lim) begin
                    w_pt  = 1'b1;
                    n_pts = r_pts + 14'd1;
                end
                n_sidx = w_sinc;
                if (w_sinc >= r_total) begin
                    n_phase = lspd_pkg::PH_HUNT;
                    w_mk    = (r_ptype == lspd_pkg::TYPE_FRAME);
                end else begin
                    n_phase = lspd_pkg::PH_S_LO;
                end
            end
            default: n_phase = lspd_pkg::PH_HUNT;
        endcase
        if (w_mk) begin
            n_fc  = r_fc + 16'd1;
            n_pts = 14'd0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lspd_pkg::ST_IDLE: if (w_acc && w_pt) n_state = lspd_pkg::ST_CALC;
            lspd_pkg::ST_CALC: begin
                if (w_done) n_state = r_mk ? lspd_pkg::ST_MARK : lspd_pkg::ST_IDLE;
            end
            lspd_pkg::ST_MARK: if (!r_ov) n_state = lspd_pkg::ST_IDLE;
            default:           n_state = lspd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != lspd_pkg::ST_IDLE) || r_ov;
        w_start    = w_acc && w_pt;
    end

    assign w_req = '{fa: r_fa, la: r_la, idx: r_sidx, tot: r_total, distance: w_word[15:2]};

    lspd_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_angle (w_angle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lspd_pkg::ST_IDLE;
            r_phase <= lspd_pkg::PH_HUNT;
            r_ptype <= 8'd0;
            r_total <= 8'd0;
            r_fa    <= 15'd0;
            r_la    <= 15'd0;
            r_lo    <= 8'd0;
            r_sidx  <= 8'd0;
            r_pts   <= 14'd0;
            r_fc    <= 16'd0;
            r_max   <= lspd_pkg::LIMIT_DEF;
            r_ov    <= 1'b0;
            r_mk    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_max <= i_cfg_wdata;
            if (w_acc) begin
                r_phase <= n_phase;
                r_ptype <= n_ptype;
                r_total <= n_total;
                r_fa    <= n_fa;
                r_la    <= n_la;
                r_lo    <= n_lo;
                r_sidx  <= n_sidx;
                r_pts   <= n_pts;
                r_fc    <= n_fc;
                r_mk    <= w_mk;
            end
            if ((w_acc && !w_pt && w_mk) || (r_state == lspd_pkg::ST_CALC && w_done)
                || (r_state == lspd_pkg::ST_MARK && !r_ov)) begin
                r_ov <= 1'b1;
            end else if (w_xfer) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_dist <= w_word[15:2];
            r_fn   <= r_fc;
        end
        if (w_acc && !w_pt && w_mk) begin
            r_kind  <= 1'b1;
            r_ang   <= 17'sd0;
            r_odist <= 14'd0;
            r_ofn   <= r_fc;
            r_last  <= 1'b1;
        end else if (r_state == lspd_pkg::ST_CALC && w_done) begin
            r_kind  <= 1'b0;
            r_ang   <= w_angle;
            r_odist <= r_dist;
            r_ofn   <= r_fn;
            r_last  <= !r_mk;
        end else if (r_state == lspd_pkg::ST_MARK && !r_ov) begin
            r_kind  <= 1'b1;
            r_ang   <= 17'sd0;
            r_odist <= 14'd0;
            r_ofn   <= r_fn;
            r_last  <= 1'b1;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_kind         = r_kind;
    assign o_angle_q6     = r_ang;
    assign o_distance     = r_odist;
    assign o_frame_number = r_ofn;
    assign o_last         = r_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lspd_pkg::ST_CALC) |-> !r_ov)
        else $error("result register busy during angle calculation");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind) |-> (o_distance == 14'd0 && o_angle_q6 == 17'sd0 && o_last))
        else $error("malformed end of frame marker");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_angle_q6 >= -17'sd8192))
        else $error("angle below saturation floor");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_mk) |=> (r_fc == $past(r_fc) + 16'd1 && r_pts == 14'd0))
        else $error("frame count not advanced on marker");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lidar scan packet decoder. A directed table
// covers header handling, empty and two-result packets, wrapped spans and
// the frame limit; random packets, noise and broken headers follow. Every
// accepted byte runs through a local model of the parser and the angle math,
// and each output transfer is compared against the oldest expected point.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic               kind;
        logic signed [16:0] angle;
        logic [13:0]        distance;
        logic [15:0]        frame;
        logic               last;
    } t_point;

    typedef struct {
        logic [7:0] b;
        bit         chk;
        t_point     e;
    } t_row;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 120;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               in_valid    = 1'b0;
    logic [7:0]         in_byte     = 8'd0;
    logic               out_stall   = 1'b0;
    logic               cfg_we      = 1'b0;
    logic [13:0]        cfg_wdata   = 14'd0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_kind;
    logic signed [16:0] o_angle_q6;
    logic [13:0]        o_distance;
    logic [15:0]        o_frame_number;
    logic               o_last;

    lidar_scan_packet_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_kind         (o_kind),
        .o_angle_q6     (o_angle_q6),
        .o_distance     (o_distance),
        .o_frame_number (o_frame_number),
        .o_last         (o_last),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_row   tx_q[$];
    t_point pending_pts[$];
    int     fail_count = 0;
    int     cycles = 0;
    int     burst_left = 0;
    int     gap_left = 0;
    int     hold_ticket = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     mode = 0;
    int     mode_left = 0;

    // parser model state
    lspd_pkg::t_phase m_phase = lspd_pkg::PH_HUNT;
    logic [7:0]  m_type = 0, m_total = 0, m_low = 0, m_index = 0;
    logic [14:0] m_start = 0, m_end = 0;
    logic [13:0] m_points = 0, m_limit = lspd_pkg::LIMIT_DEF;
    logic [15:0] m_frame = 0;

    const longint atan_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    function automatic longint range_fix(input logic [13:0] d);
        longint x, y, acc, dx, dy;
        acc = 0;
        if (d == 0) return 0;
        x = 64'sd901500 * longint'(d);
        y = 64'sd1916 * (64'sd100 * longint'(d) - 64'sd9015);
        for (int k = 0; k < 16; k++) begin
            if (y == 0) break;
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0) begin
                x += dx; y -= dy; acc += atan_tab[k];
            end else begin
                x -= dx; y += dy; acc -= atan_tab[k];
            end
        end
        return (acc + 512) >>> 10;
    endfunction

    function automatic void close_packet(inout t_point r[2], inout int n);
        m_phase = lspd_pkg::PH_HUNT;
        if (m_type == lspd_pkg::TYPE_FRAME) begin
            r[n] = '{1'b1, 17'sd0, 14'd0, m_frame, 1'b0};
            n++;
            m_frame = m_frame + 16'd1;
            m_points = 0;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, output t_point r[2],
                                        output int n);
        logic [15:0] word;
        logic [13:0] lim, d;
        longint f, l, span, ang;
        n = 0;
        r[0] = '{0, 0, 0, 0, 0};
        r[1] = r[0];
        word = {b, m_low};
        case (m_phase)
            lspd_pkg::PH_HUNT:   if (b == lspd_pkg::SYNC1) m_phase = lspd_pkg::PH_SYNC2;
            lspd_pkg::PH_SYNC2: begin
                m_phase = (b == lspd_pkg::SYNC2) ? lspd_pkg::PH_TYPE : lspd_pkg::PH_HUNT;
            end
            lspd_pkg::PH_TYPE:   begin m_type = b; m_phase = lspd_pkg::PH_COUNT; end
            lspd_pkg::PH_COUNT:  begin m_total = b; m_phase = lspd_pkg::PH_FSA_LO; end
            lspd_pkg::PH_FSA_LO: begin m_low = b; m_phase = lspd_pkg::PH_FSA_HI; end
            lspd_pkg::PH_LSA_LO: begin m_low = b; m_phase = lspd_pkg::PH_LSA_HI; end
            lspd_pkg::PH_FSA_HI: begin m_start = word[15:1]; m_phase = lspd_pkg::PH_LSA_LO; end
            lspd_pkg::PH_LSA_HI: begin m_end = word[15:1]; m_phase = lspd_pkg::PH_CS_LO; end
            lspd_pkg::PH_CS_LO:  m_phase = lspd_pkg::PH_CS_HI;
            lspd_pkg::PH_CS_HI: begin
                m_index = 0;
                if (m_total == 0) close_packet(r, n);
                else m_phase = lspd_pkg::PH_S_LO;
            end
            lspd_pkg::PH_S_LO:   begin m_low = b; m_phase = lspd_pkg::PH_S_HI; end
            lspd_pkg::PH_S_HI: begin
                d = word[15:2];
                lim = (m_limit == 0 || m_limit > lspd_pkg::LIMIT_MAX) ? lspd_pkg::LIMIT_DEF
                                                                       : m_limit;
                if (m_points < lim) begin
                    f = longint'(m_start);
                    l = longint'(m_end);
                    span = l - f;
                    if (l < f) span += 23040;
                    ang = f + (span * longint'(m_index)) / longint'(m_total) - range_fix(d);
                    if (ang > 65535) ang = 65535;
                    if (ang < -8192) ang = -8192;
                    r[n] = '{1'b0, ang[16:0], d, m_frame, 1'b0};
                    n++;
                    m_points++;
                end
                m_index = m_index + 8'd1;
                if (m_index >= m_total) close_packet(r, n);
                else m_phase = lspd_pkg::PH_S_LO;
            end
            default:   m_phase = lspd_pkg::PH_HUNT;
        endcase
        if (n > 0) r[n-1].last = 1'b1;
    endfunction

    // sender: bursts of transfers with random gaps, prediction on acceptance
    always @(posedge i_clk) begin : sender
        t_point r[2];
        int     n;
        t_row   t;
        bit     take;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            take = in_valid && !o_in_stall;
            if (take) begin
                t = tx_q.pop_front();
                decode_byte(t.b, r, n);
                if (t.chk) begin
                    pending_pts.push_back(t.e);
                end else begin
                    for (int i = 0; i < n; i++) pending_pts.push_back(r[i]);
                end
            end
            if (in_valid && !take) begin
                // hold
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (tx_q.size() > 0) begin
                in_valid <= 1'b1;
                in_byte  <= tx_q[0].b;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 4) == 0) ? $urandom_range(10, 80)
                                                              : $urandom_range(0, 4);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall patterns plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_ticket) begin
            hold_seen <= hold_ticket;
            hold_left <= 600;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                mode      <= $urandom_range(0, 3);
                mode_left <= $urandom_range(5, 60);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 1) == 0);
                2:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : result_check
        t_point e;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_pts.size() == 0) begin
                $error("unexpected result kind %0d angle %0d", o_kind, o_angle_q6);
                fail_count++;
            end else begin
                e = pending_pts.pop_front();
                if (o_kind !== e.kind) begin
                    $error("kind expected %0d got %0d", e.kind, o_kind);
                    fail_count++;
                end
                if (o_angle_q6 !== e.angle) begin
                    $error("angle_q6 expected %0d got %0d", e.angle, o_angle_q6);
                    fail_count++;
                end
                if (o_distance !== e.distance) begin
                    $error("distance expected %0d got %0d", e.distance, o_distance);
                    fail_count++;
                end
                if (o_frame_number !== e.frame) begin
                    $error("frame_number expected %0d got %0d", e.frame, o_frame_number);
                    fail_count++;
                end
                if (o_last !== e.last) begin
                    $error("last expected %0d got %0d", e.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("lidar_scan_packet_decoder verification failed");
            $finish;
        end
    end

    task automatic send(input logic [7:0] b);
        tx_q.push_back('{b, 1'b0, '{0, 0, 0, 0, 0}});
    endtask

    task automatic send_pkt(input logic [7:0] kind, input logic [7:0] cnt);
        logic [15:0] sw, ew;
        sw = 16'($urandom);
        ew = 16'($urandom);
        send(lspd_pkg::SYNC1); send(lspd_pkg::SYNC2); send(kind); send(cnt);
        send(sw[7:0]); send(sw[15:8]); send(ew[7:0]); send(ew[15:8]);
        send(8'($urandom)); send(8'($urandom));
        for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send(8'($urandom_range(0, 3))); send(8'd0);
            end else begin
                send(8'($urandom)); send(8'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (tx_q.size() != 0 || in_valid || pending_pts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [13:0] v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        m_limit = v;
    endtask

    initial begin : main
        t_row          table_rows[$];
        logic [7:0]    dir_bytes[$];
        logic [13:0]   limits[7];
        int            sent;
        int            sel;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: empty frame packet, broken headers, zero sample,
        // wrapped span with extreme words and a two-result last sample
        dir_bytes = '{8'hAA, 8'h55, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00};
        foreach (dir_bytes[i]) table_rows.push_back('{dir_bytes[i], 1'b0, '{0, 0, 0, 0, 0}});
        table_rows[9].chk = 1'b1;
        table_rows[9].e   = '{1'b1, 17'sd0, 14'd0, 16'd0, 1'b1};
        dir_bytes = '{8'hAA, 8'h12, 8'hAA, 8'hAA, 8'h55,
                      8'hAA, 8'h55, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'h00};
        foreach (dir_bytes[i]) table_rows.push_back('{dir_bytes[i], 1'b0, '{0, 0, 0, 0, 0}});
        table_rows[$].chk = 1'b1;
        table_rows[$].e   = '{1'b0, 17'sd0, 14'd0, 16'd1, 1'b1};
        foreach (table_rows[i]) tx_q.push_back(table_rows[i]);
        dir_bytes = '{8'hAA, 8'h55, 8'h01, 8'h02, 8'hFF, 8'hFF, 8'h02, 8'h00,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00};
        foreach (dir_bytes[i]) send(dir_bytes[i]);
        drain();

        // frame full: tight limit, more samples than the limit
        set_limit(14'd3);
        send_pkt(8'h01, 8'd20);
        drain();

        limits = '{14'd0, 14'd10000, 14'd16383, 14'd1, 14'd2, 14'd5, 14'd1000};
        for (int ph = 0; ph < 6; ph++) begin
            set_limit((ph == 5) ? 14'($urandom_range(1, 10000)) : limits[ph]);
            sent = 0;
            while (sent < 75) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) begin
                    sel = $urandom_range(0, 99);
                    send_pkt(sel < 50 ? 8'h01 : (sel < 85 ? 8'h00 : 8'($urandom)),
                             $urandom_range(0, 9) == 0 ? 8'd0 :
                             ($urandom_range(0, 9) == 0 ? 8'($urandom_range(7, 30))
                                                       : 8'($urandom_range(1, 6))));
                end else if (sel < 85) begin
                    repeat ($urandom_range(1, 4)) send(8'($urandom));
                end else begin
                    send(lspd_pkg::SYNC1);
                    send(8'($urandom));
                end
                sent = sent + 1;
                sent = 75 - (75 - sent);
                if (tx_q.size() >= 55) sent = 75;
            end
            if (ph == 2) hold_ticket = hold_ticket + 1;
            drain();
        end
        set_limit(14'd1000);

        if (fail_count == 0) begin
            $display("lidar_scan_packet_decoder verification clean");
        end else begin
            $display("lidar_scan_packet_decoder verification failed");
        end
        $finish;
    end

endmodule
